### rtl/discan_pkg.sv
package discan_pkg;

    // Timer width of the settle and interval counters (8 to 32)
    localparam int TIMER_W = 16;
    localparam int CFG_W   = 16;
    localparam int CMP_W   = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;
    localparam int STEP_W  = 4;
    localparam int CH_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETEST_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] SETTLE_TICKS_RST    = 16'd5;
    localparam logic [CFG_W-1:0] RETEST_INTERVAL_RST = 16'd60000;

    // Sequence steps
    localparam logic [STEP_W-1:0] STEP_FIRST     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SCAN_LAST = 4'd4;
    localparam logic [STEP_W-1:0] STEP_TEST_LAST = 4'd12;
    localparam logic [STEP_W-1:0] STEP_WAIT      = 4'd13;

    // Test stimulus codes
    localparam logic [1:0] STIM_NONE   = 2'd0;
    localparam logic [1:0] STIM_OPEN   = 2'd1;
    localparam logic [1:0] STIM_TENK   = 2'd2;
    localparam logic [1:0] STIM_CLOSED = 2'd3;

    // Channel codes
    localparam logic [1:0] CODE_CLOSED   = 2'd2;
    localparam logic [1:0] EXP_OPEN      = 2'd1;
    localparam logic [1:0] EXP_TENK      = 2'd3;
    localparam logic [1:0] EXP_CLOSED    = 2'd2;

    typedef struct packed {
        logic [7:0] port_byte;
        logic       power_on;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      strobe_group;
        logic [1:0]      test_stimulus;
        logic            sensor_power;
        logic [CH_W-1:0] channel_state;
        logic [CH_W-1:0] channel_valid;
        logic [CH_W-1:0] channel_fail;
        logic            sampled;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ticks;
        logic [CFG_W-1:0] retest_interval;
    } t_cfg;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        return (v == {TIMER_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

### rtl/discan_step.sv
module discan_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  discan_pkg::t_in_item i_item,
    input  discan_pkg::t_cfg     i_cfg,
    output discan_pkg::t_out_item o_result
);
    import discan_pkg::*;

    logic [STEP_W-1:0]  r_step,      n_step;
    logic               r_power_prev, n_power_prev;
    logic [TIMER_W-1:0] r_settle,    n_settle;
    logic [TIMER_W-1:0] r_interval,  n_interval;
    logic [CH_W-1:0]    r_work_state, n_work_state;
    logic [CH_W-1:0]    r_work_valid, n_work_valid;
    logic [CH_W-1:0]    r_work_fail,  n_work_fail;
    logic [CH_W-1:0]    r_pub_state,  n_pub_state;
    logic [CH_W-1:0]    r_pub_valid,  n_pub_valid;
    logic [CH_W-1:0]    r_pub_fail,   n_pub_fail;

    logic [7:0]        rev;
    logic [STEP_W-1:0] s1;
    logic [1:0]        phase;
    logic [1:0]        expect_code;
    logic [1:0]        grp;
    logic [1:0]        stim;
    logic              smp;
    logic              clr_settle;
    logic              clr_interval;
    logic              settle_hit;
    logic              interval_hit;
    logic [3:0]        m_valid;
    logic [3:0]        m_state;
    logic [3:0]        m_fail;
    logic [1:0]        code;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            rev[7-i] = i_item.port_byte[i];
        end
    end

    always_comb begin
        n_step       = r_step;
        n_power_prev = r_power_prev;
        n_settle     = r_settle;
        n_interval   = r_interval;
        n_work_state = r_work_state;
        n_work_valid = r_work_valid;
        n_work_fail  = r_work_fail;
        n_pub_state  = r_pub_state;
        n_pub_valid  = r_pub_valid;
        n_pub_fail   = r_pub_fail;
        clr_settle   = 1'b0;
        clr_interval = 1'b0;
        grp          = 2'd0;
        stim         = STIM_NONE;
        smp          = 1'b0;

        // mode change restarts the sequence, both timers and the working words (published words are kept)
        if (i_item.power_on != r_power_prev) begin
            n_power_prev = i_item.power_on;
            n_step       = STEP_FIRST;
            n_settle     = '0;
            n_interval   = '0;
            clr_settle   = 1'b1;
            clr_interval = 1'b1;
            n_work_state = '0;
            n_work_valid = '0;
            n_work_fail  = '0;
        end

        s1    = n_step - 1'b1;
        phase = s1[3:2];
        case (phase)
            2'd0:    expect_code = EXP_OPEN;
            2'd1:    expect_code = EXP_TENK;
            default: expect_code = EXP_CLOSED;
        endcase

        settle_hit   = CMP_W'(n_settle) > CMP_W'(i_cfg.settle_ticks);
        interval_hit = CMP_W'(n_interval) > CMP_W'(i_cfg.retest_interval);

        for (int k = 0; k < 4; k++) begin
            code       = rev[2*k +: 2];
            m_valid[k] = ~code[1];
            m_state[k] = (code == CODE_CLOSED);
            m_fail[k]  = (code != expect_code);
        end

        if (n_power_prev) begin
            if (n_step >= STEP_FIRST && n_step <= STEP_SCAN_LAST) begin
                grp = s1[1:0];
                if (settle_hit) begin
                    smp = 1'b1;
                    if (n_step == STEP_FIRST) begin
                        n_work_state = '0;
                        n_work_valid = '0;
                    end
                    n_work_valid = n_work_valid | (CH_W'(m_valid) << {grp, 2'b00});
                    n_work_state = n_work_state | (CH_W'(m_state) << {grp, 2'b00});
                    n_settle     = '0;
                    clr_settle   = 1'b1;
                    if (n_step == STEP_SCAN_LAST) begin
                        n_pub_state = n_work_state;
                        n_pub_valid = n_work_valid;
                        n_step      = STEP_FIRST;
                    end else begin
                        n_step = n_step + 1'b1;
                    end
                end
            end else begin
                n_step = STEP_FIRST;
            end
        end else begin
            if (n_step >= STEP_FIRST && n_step <= STEP_TEST_LAST) begin
                grp  = s1[1:0];
                stim = phase + 2'd1;
                if (settle_hit) begin
                    smp = 1'b1;
                    if (n_step == STEP_FIRST) begin
                        n_work_fail = '0;
                    end
                    n_work_fail = n_work_fail | (CH_W'(m_fail) << {grp, 2'b00});
                    n_settle    = '0;
                    clr_settle  = 1'b1;
                    if (n_step == STEP_TEST_LAST) begin
                        n_pub_fail = n_work_fail;
                        n_step     = STEP_WAIT;
                    end else begin
                        n_step = n_step + 1'b1;
                    end
                end
            end else if (n_step == STEP_WAIT) begin
                if (interval_hit) begin
                    n_interval   = '0;
                    clr_interval = 1'b1;
                    n_step       = STEP_FIRST;
                end
            end else begin
                n_step = STEP_FIRST;
            end
        end

        if (!clr_settle) begin
            n_settle = sat_inc(n_settle);
        end
        if (!clr_interval) begin
            n_interval = sat_inc(n_interval);
        end
    end

    always_comb begin
        o_result.strobe_group  = grp;
        o_result.test_stimulus = stim;
        o_result.sensor_power  = n_power_prev;
        o_result.channel_state = n_pub_state;
        o_result.channel_valid = n_pub_valid;
        o_result.channel_fail  = n_pub_fail;
        o_result.sampled       = smp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= STEP_FIRST;
            r_power_prev <= 1'b1;
            r_settle     <= '0;
            r_interval   <= '0;
            r_work_state <= '0;
            r_work_valid <= '0;
            r_work_fail  <= '0;
            r_pub_state  <= '0;
            r_pub_valid  <= '0;
            r_pub_fail   <= '0;
        end else if (i_adv) begin
            r_step       <= n_step;
            r_power_prev <= n_power_prev;
            r_settle     <= n_settle;
            r_interval   <= n_interval;
            r_work_state <= n_work_state;
            r_work_valid <= n_work_valid;
            r_work_fail  <= n_work_fail;
            r_pub_state  <= n_pub_state;
            r_pub_valid  <= n_pub_valid;
            r_pub_fail   <= n_pub_fail;
        end
    end

endmodule

### rtl/discrete_input_scan_selftest.sv
// Discrete input scanner with power-off self-test. Each input transaction is one
// timer tick carrying the port byte and the sensor-power request; it yields exactly
// one result transaction with the strobe/stimulus selection, the power mode, the
// published state/valid/fail words and a sampled flag. A transaction sits in an
// input register, the step logic computes its result combinationally, and the
// result lands in an output register. One transaction per cycle is sustained
// while the output is not stalled. A stalled result holds the input register, so
// the input stalls only while both registers are full and the output is stalled.
// Configuration (settle_ticks at index 0, retest_interval at index 1) is always
// ready and should be written only while no transaction is in flight.
module discrete_input_scan_selftest (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  discan_pkg::t_in_item          i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output discan_pkg::t_out_item         o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [discan_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [discan_pkg::CFG_W-1:0]  i_cfg_data
);
    import discan_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_cfg      r_cfg;
    t_out_item step_result;
    logic      adv;
    logic      in_take;

    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    discan_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= step_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks    <= SETTLE_TICKS_RST;
            r_cfg.retest_interval <= RETEST_INTERVAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SETTLE_TICKS:    r_cfg.settle_ticks    <= i_cfg_data;
                CFG_RETEST_INTERVAL: r_cfg.retest_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### rtl/discan_checker.sv
module discan_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input discan_pkg::t_out_item         o_out_data
);
    import discan_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // input side never blocks while the output register is empty
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // powered scanning never drives a test stimulus
    a_power_no_stim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sensor_power |-> o_out_data.test_stimulus == STIM_NONE)
        else $error("stimulus with sensor power on");

    // self-test with no stimulus (waiting or resync) selects group 0 and samples nothing
    a_idle_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.sensor_power && o_out_data.test_stimulus == STIM_NONE
        |-> o_out_data.strobe_group == 2'd0 && !o_out_data.sampled)
        else $error("self-test idle tick selects a group or samples");

endmodule

bind discrete_input_scan_selftest discan_checker u_discan_checker (.*);
